@@ sv/rhcl_pkg.sv @@
// ----------------------------------------------------------------------------
// rhcl_pkg
// Shared types, phase codes and serial-type length lookup for the record
// header column locator.
// ----------------------------------------------------------------------------
package rhcl_pkg;

    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 16;
    localparam int OFF_W    = 24;
    localparam int ACC_W    = 32;
    localparam int PHASE_W  = 3;
    localparam int VCNT_W   = 3;

    localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_RECLEN = 3'd1;
    localparam logic [PHASE_W-1:0] PH_ROWID  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_HDRLEN = 3'd3;
    localparam logic [PHASE_W-1:0] PH_TYPES  = 3'd4;
    localparam logic [PHASE_W-1:0] PH_DONE   = 3'd5;

    localparam logic [VCNT_W-1:0] VARINT_SHORT_MAX = 3'd3;
    localparam logic [VCNT_W-1:0] VARINT_LONG_MAX  = 3'd5;

    localparam logic [OFF_W-1:0] OFFSET_MAX = 24'hFF_FFFF;

    localparam int FIXED_TYPES = 12;
    localparam logic [ACC_W-1:0] BLOB_BASE = 32'd12;
    localparam logic [3:0] FIXED_LENS [FIXED_TYPES] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd6, 4'd8, 4'd8, 4'd0, 4'd0, 4'd0, 4'd0
    };

    typedef struct packed {
        logic [LEN_W-1:0] record_length;
        logic [LEN_W-1:0] header_length;
        logic [OFF_W-1:0] data_offset;
        logic [LEN_W-1:0] type_offset;
        logic             malformed;
    } t_result;

    // text and blob both reduce to (t - 12) >> 1
    function automatic logic [ACC_W-1:0] serial_len(input logic [ACC_W-1:0] t);
        logic [ACC_W-1:0] diff;
        diff = t - BLOB_BASE;
        if (t < BLOB_BASE) begin
            serial_len = ACC_W'(FIXED_LENS[t[3:0]]);
        end else begin
            serial_len = {1'b0, diff[ACC_W-1:1]};
        end
    endfunction

endpackage

@@ sv/record_header_column_locator.sv @@
// ----------------------------------------------------------------------------
// record_header_column_locator
// Walks a table-leaf record header byte by byte and reports where the data
// and serial type of a chosen column sit.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  input     in         i_valid / o_ready    i_record_byte, i_record_start,
//                                            i_target_column
//  result    out        o_valid / i_ready    o_record_length, o_header_length,
//                                            o_data_offset, o_type_offset,
//                                            o_malformed
//
//  one record byte per cycle unless a held result stalls parsing; an accepted byte waits in the input register
//  a result is written to the output register when the parse core steps its last byte
//  the varint step and offset add in the parse core are combinational
//  a held result stalls parsing; the input register takes one byte, then stalls
//  synchronous active-low reset returns the parser to idle
// ----------------------------------------------------------------------------
module record_header_column_locator #(
    parameter int MAX_COLUMNS = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [rhcl_pkg::BYTE_W-1:0]     i_record_byte,
    input  logic                            i_record_start,
    input  logic [rhcl_pkg::BYTE_W-1:0]     i_target_column,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [rhcl_pkg::LEN_W-1:0]      o_record_length,
    output logic [rhcl_pkg::LEN_W-1:0]      o_header_length,
    output logic [rhcl_pkg::OFF_W-1:0]      o_data_offset,
    output logic [rhcl_pkg::LEN_W-1:0]      o_type_offset,
    output logic                            o_malformed
);
    import rhcl_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_start;
    logic [BYTE_W-1:0] r_in_target;
    logic              r_out_valid;
    t_result           r_out;

    logic    w_advance;
    logic    w_res_valid;
    t_result w_res;

    assign w_advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || w_advance;

    rhcl_parse_core #(
        .MAX_COLUMNS(MAX_COLUMNS)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (w_advance),
        .i_record_byte   (r_in_byte),
        .i_record_start  (r_in_start),
        .i_target_column (r_in_target),
        .o_result_valid  (w_res_valid),
        .o_result        (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte   <= i_record_byte;
            r_in_start  <= i_record_start;
            r_in_target <= i_target_column;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || i_ready) begin
            r_out_valid <= w_advance && w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_record_length = r_out.record_length;
    assign o_header_length = r_out.header_length;
    assign o_data_offset   = r_out.data_offset;
    assign o_type_offset   = r_out.type_offset;
    assign o_malformed     = r_out.malformed;

endmodule

@@ sv/rhcl_parse_core.sv @@
// ----------------------------------------------------------------------------
// rhcl_parse_core
// Per-byte varint decoder and header walker; holds the parse state and
// produces at most one result for each stepped byte.
// ----------------------------------------------------------------------------
module rhcl_parse_core #(
    parameter int MAX_COLUMNS = 256
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_step,
    input  logic [rhcl_pkg::BYTE_W-1:0]     i_record_byte,
    input  logic                            i_record_start,
    input  logic [rhcl_pkg::BYTE_W-1:0]     i_target_column,
    output logic                            o_result_valid,
    output rhcl_pkg::t_result               o_result
);
    import rhcl_pkg::*;

    localparam int CW = $clog2(MAX_COLUMNS);

    logic [PHASE_W-1:0] r_phase,  n_phase;
    logic [ACC_W-1:0]   r_acc,    n_acc;
    logic [VCNT_W-1:0]  r_cnt,    n_cnt;
    logic [LEN_W-1:0]   r_pos,    n_pos;
    logic [OFF_W-1:0]   r_doff,   n_doff;
    logic [CW-1:0]      r_cols,   n_cols;
    logic [LEN_W-1:0]   r_reclen, n_reclen;
    logic [LEN_W-1:0]   r_hdrlen, n_hdrlen;
    logic [LEN_W-1:0]   r_hlpos,  n_hlpos;

    always_comb begin
        logic               active;
        logic               cont;
        logic [VCNT_W-1:0]  maxb;
        logic [PHASE_W-1:0] cur_phase;
        logic [ACC_W-1:0]   value;
        logic [LEN_W-1:0]   next_pos;
        logic [ACC_W-1:0]   len;
        logic [ACC_W:0]     sum;

        n_phase  = r_phase;
        n_acc    = r_acc;
        n_cnt    = r_cnt;
        n_pos    = r_pos;
        n_doff   = r_doff;
        n_cols   = r_cols;
        n_reclen = r_reclen;
        n_hdrlen = r_hdrlen;
        n_hlpos  = r_hlpos;
        o_result_valid = 1'b0;
        o_result = '0;
        active   = 1'b0;
        cont     = 1'b0;
        maxb     = VARINT_LONG_MAX;
        cur_phase = r_phase;
        value    = '0;
        next_pos = '0;
        len      = '0;
        sum      = '0;

        if (i_step) begin
            active = 1'b1;
            if (i_record_start) begin
                n_phase  = PH_RECLEN;
                n_acc    = '0;
                n_cnt    = '0;
                n_pos    = '0;
                n_doff   = '0;
                n_reclen = '0;
                n_hdrlen = '0;
                n_hlpos  = '0;
                if (int'(i_target_column) > MAX_COLUMNS - 1) begin
                    n_cols = CW'(MAX_COLUMNS - 1);
                end else begin
                    n_cols = CW'(i_target_column);
                end
            end else if (r_phase == PH_IDLE || r_phase >= PH_DONE) begin
                active = 1'b0;
            end else begin
                n_pos = r_pos + 1'b1;
            end

            if (active) begin
                cur_phase = n_phase;
                n_acc = {n_acc[ACC_W-8:0], i_record_byte[6:0]};
                n_cnt = n_cnt + 1'b1;
                if (cur_phase == PH_RECLEN || cur_phase == PH_HDRLEN) begin
                    maxb = VARINT_SHORT_MAX;
                end
                cont = i_record_byte[7] && (n_cnt < maxb);
                if (!cont) begin
                    value    = n_acc;
                    n_acc    = '0;
                    n_cnt    = '0;
                    next_pos = n_pos + 1'b1;
                    unique case (cur_phase)
                        PH_RECLEN: begin
                            n_reclen = value[LEN_W-1:0];
                            n_phase  = PH_ROWID;
                        end
                        PH_ROWID: begin
                            n_hlpos = next_pos;
                            n_phase = PH_HDRLEN;
                        end
                        PH_HDRLEN: begin
                            n_hdrlen = value[LEN_W-1:0];
                            n_doff   = OFF_W'(n_hlpos) + OFF_W'(value[LEN_W-1:0]);
                            if (n_cols == '0) begin
                                o_result_valid = 1'b1;
                                o_result.record_length = n_reclen;
                                o_result.header_length = n_hdrlen;
                                o_result.data_offset   = n_doff;
                                o_result.type_offset   = next_pos;
                                n_phase = PH_DONE;
                            end else begin
                                n_phase = PH_TYPES;
                            end
                        end
                        PH_TYPES: begin
                            len = serial_len(value);
                            sum = (ACC_W+1)'(n_doff) + {1'b0, len};
                            if (sum > (ACC_W+1)'(OFFSET_MAX)) begin
                                n_doff = OFFSET_MAX;
                            end else begin
                                n_doff = sum[OFF_W-1:0];
                            end
                            n_cols = n_cols - 1'b1;
                            if (OFF_W'(next_pos) > n_doff) begin
                                o_result_valid = 1'b1;
                                o_result.record_length = n_reclen;
                                o_result.header_length = n_hdrlen;
                                o_result.malformed     = 1'b1;
                                n_phase = PH_DONE;
                            end else if (n_cols == '0) begin
                                o_result_valid = 1'b1;
                                o_result.record_length = n_reclen;
                                o_result.header_length = n_hdrlen;
                                o_result.data_offset   = n_doff;
                                o_result.type_offset   = next_pos;
                                n_phase = PH_DONE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_acc    <= '0;
            r_cnt    <= '0;
            r_pos    <= '0;
            r_doff   <= '0;
            r_cols   <= '0;
            r_reclen <= '0;
            r_hdrlen <= '0;
            r_hlpos  <= '0;
        end else begin
            r_phase  <= n_phase;
            r_acc    <= n_acc;
            r_cnt    <= n_cnt;
            r_pos    <= n_pos;
            r_doff   <= n_doff;
            r_cols   <= n_cols;
            r_reclen <= n_reclen;
            r_hdrlen <= n_hdrlen;
            r_hlpos  <= n_hlpos;
        end
    end

endmodule

@@ tb/column_locator_checker.sv @@
// ----------------------------------------------------------------------------
// column_locator_checker
// Watches both channels of the record header column locator. Each record
// byte taken by the block is run through a behavioral parse that predicts
// the location result for the record. Each result the block hands over is
// compared with the oldest prediction. Mismatches, results with no
// prediction waiting, and the number of predictions still open are reported
// to the testbench top.
// ----------------------------------------------------------------------------
module column_locator_checker #(
    parameter int MAX_COLUMNS = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_byte_valid,
    input  logic                        i_byte_ready,
    input  logic [rhcl_pkg::BYTE_W-1:0] i_record_byte,
    input  logic                        i_record_start,
    input  logic [rhcl_pkg::BYTE_W-1:0] i_target_column,
    input  logic                        i_result_valid,
    input  logic                        i_result_ready,
    input  logic [rhcl_pkg::LEN_W-1:0]  i_record_length,
    input  logic [rhcl_pkg::LEN_W-1:0]  i_header_length,
    input  logic [rhcl_pkg::OFF_W-1:0]  i_data_offset,
    input  logic [rhcl_pkg::LEN_W-1:0]  i_type_offset,
    input  logic                        i_malformed,
    output int                          o_error_count,
    output int                          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import rhcl_pkg::*;

    localparam int MAX_REPORTS = 10;
    localparam logic [ACC_W-1:0] FIRST_BLOB_TYPE = 32'd12;
    localparam logic [ACC_W-1:0] FIRST_TEXT_TYPE = 32'd13;
    localparam logic [3:0] FIXED_TYPE_BYTES [12] = '{
        4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd6, 4'd8, 4'd8, 4'd0, 4'd0, 4'd0, 4'd0
    };

    logic [PHASE_W-1:0] phase;
    logic [ACC_W-1:0]   acc;
    logic [VCNT_W-1:0]  varint_bytes;
    logic [LEN_W-1:0]   pos;
    logic [OFF_W-1:0]   run_offset;
    logic [BYTE_W-1:0]  columns_left;
    logic [LEN_W-1:0]   rec_len;
    logic [LEN_W-1:0]   hdr_len;
    logic [LEN_W-1:0]   hdr_len_pos;

    t_result predicted_locations[$];
    int      mismatches = 0;

    initial begin
        o_error_count = 0;
        o_pending     = 0;
    end

    function automatic void clear_parse();
        phase        = PH_IDLE;
        acc          = '0;
        varint_bytes = '0;
        pos          = '0;
        run_offset   = '0;
        columns_left = '0;
        rec_len      = '0;
        hdr_len      = '0;
        hdr_len_pos  = '0;
    endfunction

    function automatic void post_location(input logic [OFF_W-1:0] data_off,
                                          input logic [LEN_W-1:0] type_off,
                                          input logic bad);
        predicted_locations.push_back({rec_len, hdr_len, data_off, type_off, bad});
        phase = PH_DONE;
    endfunction

    function automatic string describe(input t_result r);
        return $sformatf("rec_len %h hdr_len %h data_off %h type_off %h malformed %b",
                         r.record_length, r.header_length, r.data_offset,
                         r.type_offset, r.malformed);
    endfunction

    task automatic parse_byte(input logic [BYTE_W-1:0] b, input logic first,
                              input logic [BYTE_W-1:0] target);
        logic [ACC_W-1:0]  value;
        logic [ACC_W-1:0]  len;
        logic [LEN_W-1:0]  next_pos;
        logic [VCNT_W-1:0] longest;
        if (first) begin
            clear_parse();
            phase = PH_RECLEN;
            columns_left = (int'(target) > MAX_COLUMNS - 1) ? BYTE_W'(MAX_COLUMNS - 1) : target;
        end else begin
            if (phase == PH_IDLE || phase >= PH_DONE) return;
            pos = pos + 1'b1;
        end
        acc = {acc[ACC_W-8:0], b[6:0]};
        varint_bytes = varint_bytes + 1'b1;
        longest = (phase == PH_RECLEN || phase == PH_HDRLEN) ? VARINT_SHORT_MAX
                                                             : VARINT_LONG_MAX;
        if (b[7] && varint_bytes < longest) return;
        value = acc;
        acc = '0;
        varint_bytes = '0;
        next_pos = pos + 1'b1;
        case (phase)
            PH_RECLEN: begin
                rec_len = value[LEN_W-1:0];
                phase = PH_ROWID;
            end
            PH_ROWID: begin
                hdr_len_pos = next_pos;
                phase = PH_HDRLEN;
            end
            PH_HDRLEN: begin
                hdr_len = value[LEN_W-1:0];
                run_offset = OFF_W'(hdr_len_pos) + OFF_W'(hdr_len);
                if (columns_left == '0) post_location(run_offset, next_pos, 1'b0);
                else phase = PH_TYPES;
            end
            PH_TYPES: begin
                if (value < FIRST_BLOB_TYPE) len = ACC_W'(FIXED_TYPE_BYTES[value[3:0]]);
                else if (value[0]) len = (value - FIRST_TEXT_TYPE) >> 1;
                else len = (value - FIRST_BLOB_TYPE) >> 1;
                if (len > ACC_W'(OFFSET_MAX - run_offset)) run_offset = OFFSET_MAX;
                else run_offset = run_offset + len[OFF_W-1:0];
                columns_left = columns_left - 1'b1;
                if (OFF_W'(next_pos) > run_offset) post_location('0, '0, 1'b1);
                else if (columns_left == '0) post_location(run_offset, next_pos, 1'b0);
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            clear_parse();
            predicted_locations.delete();
        end else begin
            if (i_result_valid && i_result_ready) begin
                got = {i_record_length, i_header_length, i_data_offset, i_type_offset,
                       i_malformed};
                if (predicted_locations.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: result with none predicted: %s", $time, describe(got));
                end else begin
                    want = predicted_locations.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("%0t: result mismatch", $time);
                            $display("  expected %s", describe(want));
                            $display("  actual   %s", describe(got));
                        end
                    end
                end
            end
            if (i_byte_valid && i_byte_ready)
                parse_byte(i_record_byte, i_record_start, i_target_column);
        end
        o_pending     <= predicted_locations.size();
        o_error_count <= mismatches;
    end

endmodule

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the record header column locator. A short
// directed stream covers ignored bytes, target column zero, a header that
// runs into the data, saturating lengths with max-length varints and a
// restart in the middle of a record. Random records follow, mostly well
// formed with random serial types, plus short headers, cut-off records and
// noise. Both channels idle at random, the result side holds off once for a
// long stretch and the byte side pauses until all results are back.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import rhcl_pkg::*;

    localparam int MAX_COLUMNS        = 256;
    localparam int RANDOM_ITEMS       = 1750;
    localparam int WATCHDOG_LIMIT     = 2000;
    localparam int RESULT_HOLD_CYCLES = 400;
    localparam int RESULT_HOLD_AT     = 30;
    localparam int DRAIN_CYCLES       = 16;
    localparam int DIRECTED_ITEMS     = 28;

    // {record_start, target_column, record_byte}
    localparam logic [16:0] DIRECTED_STREAM [DIRECTED_ITEMS] = '{
        17'h0_FF_FF, 17'h0_00_00,
        17'h1_00_05, 17'h0_00_01, 17'h0_00_02,
        17'h1_02_08, 17'h0_00_01, 17'h0_00_01, 17'h0_00_00,
        17'h1_01_FF, 17'h0_00_FF, 17'h0_00_FF, 17'h0_00_81, 17'h0_00_00,
        17'h0_00_80, 17'h0_00_80, 17'h0_00_07,
        17'h0_00_FF, 17'h0_00_FF, 17'h0_00_FF, 17'h0_00_FF, 17'h0_00_FF,
        17'h1_07_03, 17'h0_00_81,
        17'h1_01_04, 17'h0_00_00, 17'h0_00_03, 17'h0_00_0D
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic [BYTE_W-1:0] i_record_byte;
    logic              i_record_start;
    logic [BYTE_W-1:0] i_target_column;
    logic              o_valid;
    logic              i_ready;
    logic [LEN_W-1:0]  o_record_length;
    logic [LEN_W-1:0]  o_header_length;
    logic [OFF_W-1:0]  o_data_offset;
    logic [LEN_W-1:0]  o_type_offset;
    logic              o_malformed;

    int error_count;
    int pending;
    int idle_cycles = 0;
    int record_items = 0;
    bit quiet_send = 1'b0;

    logic [BYTE_W-1:0] rec_bytes[$];

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    record_header_column_locator #(
        .MAX_COLUMNS(MAX_COLUMNS)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_record_byte  (i_record_byte),
        .i_record_start (i_record_start),
        .i_target_column(i_target_column),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_record_length(o_record_length),
        .o_header_length(o_header_length),
        .o_data_offset  (o_data_offset),
        .o_type_offset  (o_type_offset),
        .o_malformed    (o_malformed)
    );

    column_locator_checker #(
        .MAX_COLUMNS(MAX_COLUMNS)
    ) checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_byte_valid   (i_valid),
        .i_byte_ready   (o_ready),
        .i_record_byte  (i_record_byte),
        .i_record_start (i_record_start),
        .i_target_column(i_target_column),
        .i_result_valid (o_valid),
        .i_result_ready (i_ready),
        .i_record_length(o_record_length),
        .i_header_length(o_header_length),
        .i_data_offset  (o_data_offset),
        .i_type_offset  (o_type_offset),
        .i_malformed    (o_malformed),
        .o_error_count  (error_count),
        .o_pending      (pending)
    );

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // big-endian 7-bit groups; the last byte of a max-length varint may keep bit 7
    function automatic void add_varint(input logic [34:0] value, input int count,
                                       input int longest);
        logic [BYTE_W-1:0] b;
        for (int k = count - 1; k >= 0; k--) begin
            b = {k != 0, value[7*k +: 7]};
            if (k == 0 && count == longest) b[7] = 1'($urandom_range(0, 1));
            rec_bytes.push_back(b);
        end
    endfunction

    task automatic build_record(input int columns, input bit short_header);
        logic [BYTE_W-1:0] types_part[$];
        int kind;
        int n;
        int hdr_len;
        rec_bytes.delete();
        for (int c = 0; c < columns; c++) begin
            kind = $urandom_range(0, 99);
            if (kind < 55) add_varint(35'($urandom_range(0, 11)), 1, 5);
            else if (kind < 85) add_varint(35'($urandom_range(12, 127)), 1, 5);
            else if (kind < 95) add_varint(35'($urandom_range(0, 16383)), 2, 5);
            else add_varint(35'({$urandom, $urandom}), $urandom_range(3, 5), 5);
        end
        types_part = rec_bytes;
        rec_bytes.delete();
        add_varint(35'({$urandom, $urandom}), $urandom_range(1, 3), 3);
        add_varint(35'({$urandom, $urandom}), $urandom_range(1, 5), 5);
        n = $urandom_range(1, 3);
        while (types_part.size() + n >= (1 << (7 * n))) n++;
        hdr_len = types_part.size() + n;
        if (short_header) hdr_len = $urandom_range(0, hdr_len - 1);
        add_varint(35'(hdr_len), n, 3);
        foreach (types_part[k]) rec_bytes.push_back(types_part[k]);
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] value, input logic first,
                             input logic [BYTE_W-1:0] column);
        int gap;
        gap = quiet_send ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_record_byte   <= value;
        i_record_start  <= first;
        i_target_column <= column;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    task automatic hold_until_drained();
        i_valid <= 1'b0;
        wait (pending == 0);
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        int pick;
        int target;
        int cut;
        bit drained_once;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_record_byte   = '0;
        i_record_start  = 1'b0;
        i_target_column = '0;
        drained_once    = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < DIRECTED_ITEMS; k++)
            send_byte(DIRECTED_STREAM[k][7:0], DIRECTED_STREAM[k][16],
                      DIRECTED_STREAM[k][15:8]);
        hold_until_drained();

        while (record_items < RANDOM_ITEMS) begin
            quiet_send = ($urandom_range(0, 7) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 88) begin
                target = $urandom_range(0, 99);
                if (target < 2) target = 255;
                else if (target < 6) target = $urandom_range(0, 255);
                else target = $urandom_range(0, 7);
                build_record(target, pick >= 70 && pick < 80);
                // cut-off records are abandoned by the next record start
                cut = (pick >= 80) ? $urandom_range(1, rec_bytes.size() - 1)
                                   : rec_bytes.size();
                for (int k = 0; k < cut; k++)
                    send_byte(rec_bytes[k], k == 0,
                              (k == 0) ? BYTE_W'(target) : BYTE_W'($urandom));
                record_items += cut;
                if (pick < 80)
                    repeat ($urandom_range(0, 3))
                        send_byte(BYTE_W'($urandom), 1'b0, BYTE_W'($urandom));
            end else begin
                for (int k = $urandom_range(1, 8); k > 0; k--) begin
                    send_byte(BYTE_W'($urandom), $urandom_range(0, 3) == 0,
                              BYTE_W'($urandom));
                    record_items++;
                end
            end
            if (!drained_once && record_items >= RANDOM_ITEMS / 2) begin
                hold_until_drained();
                drained_once = 1'b1;
            end
        end

        i_valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin : result_sink
        int gap;
        int taken;
        bit quiet;
        i_ready = 1'b0;
        taken   = 0;
        quiet   = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (taken % 16 == 0) quiet = ($urandom_range(0, 3) == 0);
            gap = quiet ? 0 : $urandom_range(0, 6);
            // one long hold-off so the block backs up and stalls its input
            if (taken == RESULT_HOLD_AT) gap = RESULT_HOLD_CYCLES;
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid && i_ready));
            taken++;
            @(negedge i_clk);
        end
    end

endmodule
